// ----- rtl/core/utf8vf_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8vf_pkg
// Types, constants and helper functions shared by the UTF-8 filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8vf_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_CHAR = 1'b1;

	localparam logic       FILTER_ENABLE_RST    = 1'b1;
	localparam logic [7:0] REPLACEMENT_CHAR_RST = 8'd95;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;

	localparam logic [20:0] CP_LIMIT   = 21'h110000;
	localparam logic [9:0]  CP_SURR    = 10'h01B;
	localparam logic [20:0] CP_NC_LO   = 21'h00FDD0;
	localparam logic [20:0] CP_NC_HI   = 21'h00FDEF;
	localparam logic [20:0] CP_MIN_2   = 21'h000080;
	localparam logic [20:0] CP_MIN_3   = 21'h000800;
	localparam logic [20:0] CP_MIN_4   = 21'h010000;

	typedef struct packed {
		logic       filter_enable;
		logic [7:0] replacement_char;
	} cfg_t;

	// Up to four results of one input byte; only the last may be the terminator.
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      cnt;
		logic            term;
		logic            str_valid;
	} cmd_t;

	function automatic logic cp_ok(input logic [20:0] cp, input logic [2:0] len);
		logic [20:0] cp_min;
		logic        ok;
		case (len)
			LEN_2:   cp_min = CP_MIN_2;
			LEN_3:   cp_min = CP_MIN_3;
			default: cp_min = CP_MIN_4;
		endcase
		ok = (cp >= cp_min) && (cp < CP_LIMIT);
		if (cp[20:11] == CP_SURR)
			ok = 1'b0;
		if (cp >= CP_NC_LO && cp <= CP_NC_HI)
			ok = 1'b0;
		if (&cp[15:1])
			ok = 1'b0;
		return ok;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/utf8vf_in_if.sv -----
// ----------------------------------------------------------------------------
// utf8vf_in_if
// Input byte channel: valid/ready handshake with one string byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8vf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/utf8vf_out_if.sv -----
// ----------------------------------------------------------------------------
// utf8vf_out_if
// Result channel: valid/ready handshake with filtered byte and end flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8vf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_last;
	logic       string_valid;

	modport source(output valid, output out_byte, output is_last, output string_valid,
		input ready);
	modport sink(input valid, input out_byte, input is_last, input string_valid,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/core/utf8vf_front.sv -----
// ----------------------------------------------------------------------------
// utf8vf_front
// Decoder: takes one byte per transfer, tracks the open sequence and issues
// one command holding all results of that byte, when the byte has any.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8vf_front
	import utf8vf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	utf8vf_in_if.sink       in_ch,
	input  wire cfg_t       cfg,
	input  wire logic       q_full,
	output logic            push,
	output cmd_t            cmd
);

	logic [2:0]      exp_q, exp_d;
	logic [2:0]      pcnt_q, pcnt_d;
	logic [20:0]     cp_q, cp_d;
	logic            err_q, err_d;
	logic [3:0][7:0] pend_q;

	logic            pend_we;
	logic [1:0]      pend_idx;
	logic [7:0]      b;
	logic [20:0]     cp_ext;
	logic [2:0]      pcnt_inc;
	logic [2:0]      k;
	logic            err_w;
	logic [7:0]      sd;
	logic            sc;
	logic            acc;

	assign in_ch.ready = !q_full;
	assign acc         = in_ch.valid && !q_full;
	assign push        = acc && (cmd.cnt != 3'd0);

	always_comb begin
		b        = in_ch.in_byte;
		cp_ext   = {cp_q[14:0], b[5:0]};
		pcnt_inc = pcnt_q + 3'd1;
		exp_d    = exp_q;
		pcnt_d   = pcnt_q;
		cp_d     = cp_q;
		err_d    = err_q;
		pend_we  = 1'b0;
		pend_idx = pcnt_q[1:0];
		k        = 3'd0;
		err_w    = err_q;
		sd       = cfg.replacement_char;
		sc       = 1'b0;
		cmd.cnt       = 3'd0;
		cmd.term      = 1'b0;
		cmd.str_valid = 1'b0;
		for (int i = 0; i < 4; i++)
			cmd.data[i] = cfg.replacement_char;

		if (exp_q != LEN_NONE && b[7:6] == 2'b10) begin
			cp_d     = cp_ext;
			pcnt_d   = pcnt_inc;
			pend_we  = 1'b1;
			if (pcnt_inc == exp_q) begin
				exp_d  = LEN_NONE;
				pcnt_d = 3'd0;
				cp_d   = '0;
				if (cp_ok(cp_ext, exp_q)) begin
					for (int i = 0; i < 4; i++)
						cmd.data[i] = (3'(i) == pcnt_q) ? b : pend_q[i];
				end else begin
					err_d = 1'b1;
				end
				cmd.cnt = cfg.filter_enable ? exp_q : 3'd0;
			end
		end else begin
			if (exp_q != LEN_NONE) begin
				err_w  = 1'b1;
				k      = cfg.filter_enable ? pcnt_q : 3'd0;
				exp_d  = LEN_NONE;
				pcnt_d = 3'd0;
				cp_d   = '0;
			end
			err_d = err_w;
			if (b == 8'h00) begin
				sd            = 8'h00;
				sc            = 1'b1;
				cmd.term      = 1'b1;
				cmd.str_valid = !err_w;
				err_d         = 1'b0;
				exp_d         = LEN_NONE;
				pcnt_d        = 3'd0;
				cp_d          = '0;
			end else if (!b[7]) begin
				sd = b;
				sc = cfg.filter_enable;
			end else if (b[7:5] == 3'b110) begin
				exp_d    = LEN_2;
				cp_d     = {16'b0, b[4:0]};
				pcnt_d   = 3'd1;
				pend_we  = 1'b1;
				pend_idx = 2'd0;
			end else if (b[7:4] == 4'b1110) begin
				exp_d    = LEN_3;
				cp_d     = {17'b0, b[3:0]};
				pcnt_d   = 3'd1;
				pend_we  = 1'b1;
				pend_idx = 2'd0;
			end else if (b[7:3] == 5'b11110) begin
				exp_d    = LEN_4;
				cp_d     = {18'b0, b[2:0]};
				pcnt_d   = 3'd1;
				pend_we  = 1'b1;
				pend_idx = 2'd0;
			end else begin
				err_d = 1'b1;
				sc    = cfg.filter_enable;
			end
			for (int i = 0; i < 4; i++)
				cmd.data[i] = (3'(i) < k) ? cfg.replacement_char : sd;
			cmd.cnt = k + {2'b0, sc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= LEN_NONE;
			pcnt_q <= 3'd0;
			cp_q   <= '0;
			err_q  <= 1'b0;
		end else if (acc) begin
			exp_q  <= exp_d;
			pcnt_q <= pcnt_d;
			cp_q   <= cp_d;
			err_q  <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && pend_we)
			pend_q[pend_idx] <= b;
	end

endmodule

`default_nettype wire

// ----- rtl/core/utf8vf_queue.sv -----
// ----------------------------------------------------------------------------
// utf8vf_queue
// Small command queue between decoder and output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8vf_queue
	import utf8vf_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t din,
	output logic      full,
	input  wire logic pop,
	output cmd_t      dout,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

endmodule

`default_nettype wire

// ----- rtl/core/utf8vf_back.sv -----
// ----------------------------------------------------------------------------
// utf8vf_back
// Output sequencer: walks the head command one result per cycle into the
// output register while that register is empty or the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8vf_back
	import utf8vf_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cmd_t   head,
	input  wire logic   q_empty,
	output logic        pop,
	utf8vf_out_if.source out_ch
);

	logic [1:0] pos_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       sv_q;
	logic       load;
	logic       at_end;

	assign load   = !valid_q || out_ch.ready;
	assign at_end = ({1'b0, pos_q} + 3'd1) == head.cnt;
	assign pop    = load && !q_empty && at_end;

	assign out_ch.valid        = valid_q;
	assign out_ch.out_byte     = byte_q;
	assign out_ch.is_last      = last_q;
	assign out_ch.string_valid = sv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= 2'd0;
		end else if (load) begin
			valid_q <= !q_empty;
			if (!q_empty)
				pos_q <= at_end ? 2'd0 : pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			byte_q <= head.data[pos_q];
			last_q <= head.term && at_end;
			sv_q   <= head.str_valid && at_end;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/utf8_validate_filter.sv -----
// ----------------------------------------------------------------------------
// utf8_validate_filter
// UTF-8 validating filter for NUL-terminated byte strings.
//
// in_ch carries one string byte per transfer; byte 0 ends the string.
// out_ch carries results: filtered bytes (filter mode) and always one
// terminating result with is_last set and string_valid giving the verdict.
// wr_en/wr_index/wr_data write filter_enable (index 0) and
// replacement_char (index 1); write only while the block is idle.
// Input takes one byte per cycle while the command queue has room and
// out_ch gives one result per cycle while the receiver is ready. The
// output sequencer sends the results of one byte one after another. With
// the queue and the output register empty, the first result of a byte is
// registered in the queue and then in the output register. in_ch.ready
// drops while the QUEUE_DEPTH-entry command queue is full; a stalled
// receiver fills it and then holds off input.
// Reset clears the open sequence, the error flag and the queue, and sets
// filter_enable to 1 and replacement_char to 95.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_validate_filter
	import utf8vf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	utf8vf_in_if.sink                  in_ch,
	utf8vf_out_if.source               out_ch,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_enable    <= FILTER_ENABLE_RST;
			cfg_q.replacement_char <= REPLACEMENT_CHAR_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_FILTER_ENABLE:    cfg_q.filter_enable    <= wr_data[0];
				REG_REPLACEMENT_CHAR: cfg_q.replacement_char <= wr_data;
				default: ;
			endcase
		end
	end

	utf8vf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push),
		.cmd    (cmd)
	);

	utf8vf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd),
		.full   (q_full),
		.pop    (pop),
		.dout   (head),
		.empty  (q_empty)
	);

	utf8vf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire

// ----- rtl/core/utf8vf_checker.sv -----
// ----------------------------------------------------------------------------
// utf8vf_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8vf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       is_last,
	input wire logic       string_valid
);

	a_last_is_nul: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |-> out_byte == 8'h00)
		else $error("terminating result carries nonzero byte");

	a_verdict_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_valid |-> is_last)
		else $error("string_valid set on non-terminating result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_last)
			&& $stable(string_valid))
		else $error("stalled result changed");

endmodule

bind utf8_validate_filter utf8vf_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_byte     (out_ch.out_byte),
	.is_last      (out_ch.is_last),
	.string_valid (out_ch.string_valid)
);

`default_nettype wire

// ----- verif/tb_utf8_validate_filter.sv -----
// ----------------------------------------------------------------------------
// tb_utf8_validate_filter
// Self-checking bench for the UTF-8 validating filter. A driver feeds string
// bytes from a queue and a sink takes results, both with random idle bursts.
// A local decoder predicts every result and each one is checked in order.
// The run starts with hand-picked strings and then goes through several
// register settings with random strings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_utf8_validate_filter;
	import utf8vf_pkg::*;

	localparam int CYCLE_LIMIT = 100000;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_last;
		logic       string_valid;
	} filter_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	utf8vf_in_if  in_ch ();
	utf8vf_out_if out_ch ();

	utf8_validate_filter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// decoder state and register copies
	logic [7:0]  seq_buf [4];
	logic [2:0]  seq_cnt = '0;
	logic [2:0]  seq_len = LEN_NONE;
	logic [20:0] seq_cp = '0;
	logic        str_err = 1'b0;
	logic        cfg_filter = FILTER_ENABLE_RST;
	logic [7:0]  cfg_repl = REPLACEMENT_CHAR_RST;

	filter_result_t filter_out_q [$];
	logic [7:0]     src_q [$];

	int unsigned in_total = 0;
	int unsigned in_done = 0;
	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;
	bit          idle_en = 1'b1;
	int          in_gap = 0;
	int          out_gap = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void push_result(input logic [7:0] b, input logic last,
		input logic ok);
		filter_out_q.push_back('{out_byte: b, is_last: last, string_valid: ok});
	endfunction

	function automatic void clear_seq();
		seq_cnt = '0;
		seq_len = LEN_NONE;
		seq_cp  = '0;
	endfunction

	// open sequence is abandoned: one replacement per held byte
	function automatic void drop_open();
		int k;
		str_err = 1'b1;
		if (cfg_filter)
			for (k = 0; k < seq_cnt; k++)
				push_result(cfg_repl, 1'b0, 1'b0);
		clear_seq();
	endfunction

	function automatic void filter_byte(input logic [7:0] b);
		logic [20:0] cp_min;
		int          k;
		if (seq_len != LEN_NONE) begin
			if (b[7:6] == 2'b10) begin
				seq_cp = {seq_cp[14:0], b[5:0]};
				seq_buf[seq_cnt[1:0]] = b;
				seq_cnt = seq_cnt + 3'd1;
				if (seq_cnt < seq_len)
					return;
				case (seq_len)
					LEN_2:   cp_min = CP_MIN_2;
					LEN_3:   cp_min = CP_MIN_3;
					default: cp_min = CP_MIN_4;
				endcase
				if (seq_cp >= cp_min && seq_cp < CP_LIMIT && seq_cp[20:11] != CP_SURR
						&& !(seq_cp >= CP_NC_LO && seq_cp <= CP_NC_HI)
						&& seq_cp[15:1] != 15'h7FFF) begin
					if (cfg_filter)
						for (k = 0; k < seq_cnt; k++)
							push_result(seq_buf[k], 1'b0, 1'b0);
					clear_seq();
				end else begin
					drop_open();
				end
				return;
			end
			drop_open();
		end
		if (b == 8'h00) begin
			push_result(8'h00, 1'b1, !str_err);
			str_err = 1'b0;
			clear_seq();
		end else if (b[7] == 1'b0) begin
			if (cfg_filter)
				push_result(b, 1'b0, 1'b0);
		end else if (b[7:5] == 3'b110) begin
			seq_len = LEN_2;
			seq_cp = {16'h0, b[4:0]};
			seq_buf[0] = b;
			seq_cnt = 3'd1;
		end else if (b[7:4] == 4'b1110) begin
			seq_len = LEN_3;
			seq_cp = {17'h0, b[3:0]};
			seq_buf[0] = b;
			seq_cnt = 3'd1;
		end else if (b[7:3] == 5'b11110) begin
			seq_len = LEN_4;
			seq_cp = {18'h0, b[2:0]};
			seq_buf[0] = b;
			seq_cnt = 3'd1;
		end else begin
			str_err = 1'b1;
			if (cfg_filter)
				push_result(cfg_repl, 1'b0, 1'b0);
		end
	endfunction

	// stimulus helpers
	function automatic void push_item(input logic [7:0] b);
		src_q.push_back(b);
		in_total++;
	endfunction

	// encode cp in len bytes (overlong allowed), keep only the first bytes
	function automatic void push_utf8(input logic [20:0] cp, input int len,
		input int keep);
		logic [7:0] enc [4];
		int         k;
		case (len)
			1: enc[0] = {1'b0, cp[6:0]};
			2: begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end
			3: begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			default: begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (k = 0; k < keep; k++)
			push_item(enc[k]);
	endfunction

	// mostly well-formed strings, with broken sequences mixed in
	function automatic void add_random_strings(input int n);
		int unsigned first;
		int          len;
		int          kind;
		int          sz;
		int          k;
		logic [20:0] cp;
		first = in_total;
		while (in_total - first < n) begin
			len = $urandom_range(1, 10);
			for (k = 0; k < len; k++) begin
				kind = $urandom_range(0, 19);
				if (kind < 6) begin
					push_item(8'($urandom_range(1, 127)));
				end else if (kind < 9) begin
					push_utf8(21'($urandom_range('h80, 'h7FF)), 2, 2);
				end else if (kind < 12) begin
					push_utf8(21'($urandom_range('h800, 'hFFFF)), 3, 3);
				end else if (kind < 14) begin
					push_utf8(21'($urandom_range('h10000, 'h10FFFF)), 4, 4);
				end else if (kind == 14) begin
					sz = $urandom_range(2, 4);
					cp = 21'($urandom_range(0, sz == 2 ? 'h7F : sz == 3 ? 'h7FF : 'hFFFF));
					push_utf8(cp, sz, sz);
				end else if (kind == 15) begin
					case ($urandom_range(0, 3))
						0: push_utf8(21'($urandom_range('hD800, 'hDFFF)), 3, 3);
						1: push_utf8(21'($urandom_range('hFDD0, 'hFDEF)), 3, 3);
						2: begin
							cp = 21'(($urandom_range(0, 16) << 16) | 'hFFFE
								| $urandom_range(0, 1));
							sz = (cp > 'hFFFF) ? 4 : 3;
							push_utf8(cp, sz, sz);
						end
						default: push_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
					endcase
				end else if (kind == 16) begin
					sz = $urandom_range(2, 4);
					push_utf8(21'($urandom_range(0, 'h1FFFFF)), sz, $urandom_range(1, sz - 1));
				end else if (kind == 17) begin
					push_item(8'($urandom_range('h80, 'hBF)));
				end else if (kind == 18) begin
					push_item(8'($urandom_range('hF8, 'hFF)));
				end else begin
					push_item(8'($urandom_range(0, 255)));
				end
			end
			push_item(8'h00);
		end
		// sometimes leave a sequence open across the next register change
		if ($urandom_range(0, 1))
			push_utf8(21'($urandom_range('h800, 'hFFFF)), 3, $urandom_range(1, 2));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic drain();
		while (in_done != in_total || filter_out_q.size() != 0)
			@(posedge clk);
		// bytes with no result may still be in flight
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic fe, input logic [7:0] rc, input int n);
		write_reg(REG_FILTER_ENABLE, {7'b0, fe});
		write_reg(REG_REPLACEMENT_CHAR, rc);
		add_random_strings(n);
		drain();
	endtask

	// input driver
	always @(posedge clk) begin
		logic       nv;
		logic [7:0] nb;
		if (arst_n) begin
			nv = in_ch.valid;
			nb = in_ch.in_byte;
			if (!in_ch.valid || in_ch.ready) begin
				nv = 1'b0;
				if (in_gap > 0) begin
					in_gap--;
				end else if (src_q.size() != 0) begin
					if (idle_en && $urandom_range(0, 7) == 0) begin
						in_gap = $urandom_range(0, 7);
					end else begin
						nv = 1'b1;
						nb = src_q.pop_front();
					end
				end
			end
			in_ch.valid <= nv;
			in_ch.in_byte <= nb;
		end
	end

	// result sink
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap--;
				out_ch.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(0, 7);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// register mirror, prediction and checking
	always @(posedge clk) begin
		filter_result_t got;
		filter_result_t want;
		if (arst_n) begin
			if (wr_en) begin
				case (wr_index)
					REG_FILTER_ENABLE:    cfg_filter = wr_data[0];
					REG_REPLACEMENT_CHAR: cfg_repl = wr_data;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				filter_byte(in_ch.in_byte);
				in_done++;
			end
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_byte: out_ch.out_byte, is_last: out_ch.is_last,
					string_valid: out_ch.string_valid};
				if (filter_out_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected transfer: expected none, got byte %02h last %0b valid %0b",
						$time, got.out_byte, got.is_last, got.string_valid);
				end else begin
					want = filter_out_q.pop_front();
					if (got.out_byte != want.out_byte) begin
						err_cnt++;
						$display("%0t: out_byte expected %02h got %02h",
							$time, want.out_byte, got.out_byte);
					end
					if (got.is_last != want.is_last) begin
						err_cnt++;
						$display("%0t: is_last expected %0b got %0b",
							$time, want.is_last, got.is_last);
					end
					if (got.string_valid != want.string_valid) begin
						err_cnt++;
						$display("%0t: string_valid expected %0b got %0b",
							$time, want.string_valid, got.string_valid);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [7:0] directed [$];
		// valid string; overlong and surrogate; U+FDD0 and U+10FFFF;
		// stray continuation, bad lead, bad continuation, NUL inside a sequence
		directed = '{8'h7F, 8'hC2, 8'h80, 8'h00,
			8'hC1, 8'hBF, 8'hED, 8'hA0, 8'h80, 8'h00,
			8'hEF, 8'hB7, 8'h90, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
			8'h80, 8'hFF, 8'hE2, 8'h41, 8'hF0, 8'h9F, 8'h98, 8'h00};
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		out_ch.ready = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_FILTER_ENABLE;
		wr_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[k])
			push_item(directed[k]);
		add_random_strings(20);
		drain();
		run_phase(1'b0, 8'h00, 30);
		run_phase(1'b1, 8'hFF, 30);
		run_phase(1'b0, 8'($urandom_range(0, 255)), 30);
		run_phase(1'b1, 8'($urandom_range(1, 254)), 30);
		idle_en = 1'b0;
		run_phase(1'b1, 8'h3F, 20);
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
